// ----- rtl/core/fddct_pkg.sv -----
package fddct_pkg;

  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 4;
  localparam int PRESET_W   = 14;

  typedef logic [DIGIT_W-1:0] digit_t;
  // index 0 is digit A (most significant), index 3 is digit D
  typedef digit_t [NUM_DIGITS-1:0] digit_vec_t;
  typedef logic [PRESET_W-1:0] preset_t;

  localparam digit_t  DIGIT_MAX  = 4'd9;
  localparam preset_t PRESET_MAX = 14'd9999;

  // digits after reset: 0600
  localparam digit_vec_t RST_DIGITS = {4'd0, 4'd0, 4'd6, 4'd0};

  // beat kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  // key codes
  localparam logic [1:0] KEY_K1 = 2'd0;
  localparam logic [1:0] KEY_K2 = 2'd1;
  localparam logic [1:0] KEY_K3 = 2'd2;
  localparam logic [1:0] KEY_K4 = 2'd3;

  // per-cell control
  typedef struct packed {
    logic en;
    logic load;
    logic edit_inc;
    logic edit_dec;
    logic clamp;
  } cell_ctl_t;

endpackage

// ----- rtl/core/fddct_digit_cell.sv -----
module fddct_digit_cell (
  input  logic                clk,
  input  logic                rst,
  input  fddct_pkg::cell_ctl_t ctl,
  input  fddct_pkg::digit_t   rst_digit,
  input  fddct_pkg::digit_t   preset_digit,
  input  logic                borrow_in,
  output logic                borrow_out,
  output fddct_pkg::digit_t   digit,
  output fddct_pkg::digit_t   digit_next
);

  always_comb begin
    digit_next = digit;
    borrow_out = 1'b0;
    if (ctl.load) begin
      digit_next = preset_digit;
    end else if (ctl.edit_inc) begin
      digit_next = (digit >= fddct_pkg::DIGIT_MAX) ? '0 : digit + 4'd1;
    end else if (ctl.edit_dec) begin
      digit_next = (digit == '0 || digit > fddct_pkg::DIGIT_MAX) ?
                   fddct_pkg::DIGIT_MAX : digit - 4'd1;
    end else if (borrow_in) begin
      if (digit == '0) begin
        // top digit clamps at zero instead of wrapping
        digit_next = ctl.clamp ? '0 : fddct_pkg::DIGIT_MAX;
        borrow_out = 1'b1;
      end else begin
        digit_next = digit - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= rst_digit;
    end else if (ctl.en) begin
      digit <= digit_next;
    end
  end

endmodule

// ----- rtl/core/fddct_preset_conv.sv -----
module fddct_preset_conv (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  fddct_pkg::preset_t     wr_data,
  output fddct_pkg::digit_vec_t  preset_digits
);

  fddct_pkg::preset_t v;
  fddct_pkg::preset_t r1_full;
  logic [3:0]         q1;
  logic [3:0]         q1_r;
  logic [9:0]         r1_r;
  logic [9:0]         r2_full;
  logic [6:0]         r2;
  logic [6:0]         d_full;
  logic [3:0]         q2;
  logic [3:0]         q3;

  // stage 1: saturate and split off thousands
  always_comb begin
    v  = (wr_data > fddct_pkg::PRESET_MAX) ? fddct_pkg::PRESET_MAX : wr_data;
    q1 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 14'(k * 1000)) q1 = 4'(k);
    end
    r1_full = v - 14'(q1) * 14'(1000);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_r <= '0;
      r1_r <= 10'd600;
    end else if (wr_en) begin
      q1_r <= q1;
      r1_r <= r1_full[9:0];
    end
  end

  // stage 2: hundreds, tens, units from the remainder
  always_comb begin
    q2 = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r1_r >= 10'(k * 100)) q2 = 4'(k);
    end
    r2_full = r1_r - 10'(q2) * 10'(100);
    r2      = r2_full[6:0];
    q3      = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r2 >= 7'(k * 10)) q3 = 4'(k);
    end
    d_full = r2 - 7'(q3) * 7'(10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_digits <= fddct_pkg::RST_DIGITS;
    end else begin
      preset_digits <= {d_full[3:0], q3, q2, q1_r};
    end
  end

endmodule

// ----- rtl/core/four_digit_decimal_countdown_timer_core.sv -----
// four-digit decimal countdown timer
// slave channel s_*: one beat per timer tick (s_tuser = 0) or key press
//   (s_tuser = 1); s_tdata carries the key code and the long-hold flag
// master channel m_*: exactly one result beat per input beat, holding the
//   four digits, edit view flag, cursor, running flag and the finished and
//   leave pulses as they stand after that beat
// cfg_wr_en / cfg_wr_data write the preset (saturated to 9999 on load);
//   the preset goes through a two-stage binary-to-decimal converter, so a
//   beat accepted on the cycle after a write already sees the new preset
// path: an input beat enters the input register, then the digit cells and
//   flags update into the result register
// throughput: one beat per cycle while m_tready is high; the four digit cells
//   form a borrow chain from D to A that settles in the update stage
// reset: digits load 0600, timer stopped, run view, cursor on digit A,
//   preset register back to 600
// stall: while m_tready is low the result beat holds; one more input beat
//   is taken into the input register, then s_tready drops until the result
//   is taken
module four_digit_decimal_countdown_timer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] key_code, [2] key_held, [7:3] zero
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] digit_a, [7:4] digit_b, [11:8] digit_c,
                                 // [15:12] digit_d, [16] in_edit,
                                 // [18:17] cursor_pos, [19] is_running,
                                 // [20] finished, [21] leave_request, [23:22] zero
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data
);

  // input register
  logic       s1_valid;
  logic       s1_kind;
  logic [1:0] s1_key;
  logic       s1_held;
  logic       adv;

  // timer state
  logic       running;
  logic       running_next;
  logic       edit_mode;
  logic       edit_mode_next;
  logic [1:0] cursor;
  logic [1:0] cursor_next;

  // result pulses
  logic       fin;
  logic       fin_next;
  logic       leave;
  logic       leave_next;
  logic       out_valid;

  // decoded beat
  logic tick;
  logic key_run;
  logic key_edit;
  logic count_en;
  logic load;

  fddct_pkg::digit_vec_t preset_digits;
  fddct_pkg::digit_vec_t digits;
  fddct_pkg::digit_vec_t digits_next;
  fddct_pkg::cell_ctl_t  cell_ctl [fddct_pkg::NUM_DIGITS];
  logic [fddct_pkg::NUM_DIGITS:0] borrow;

  // the update stage moves when the result register is free or being drained
  assign adv      = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_kind <= s_tuser[0];
      s1_key  <= s_tdata[1:0];
      s1_held <= s_tdata[2];
    end
  end

  fddct_preset_conv u_conv (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_wr_en),
    .wr_data       (cfg_wr_data),
    .preset_digits (preset_digits)
  );

  assign tick     = (s1_kind == fddct_pkg::KIND_TICK);
  assign key_run  = (s1_kind == fddct_pkg::KIND_KEY) && !edit_mode;
  assign key_edit = (s1_kind == fddct_pkg::KIND_KEY) && edit_mode;
  assign count_en = tick && running;
  assign load     = (key_run && s1_key == fddct_pkg::KEY_K3) ||
                    (key_edit && s1_key == fddct_pkg::KEY_K4);

  // borrow enters at digit D and ripples toward A
  assign borrow[fddct_pkg::NUM_DIGITS] = count_en;

  for (genvar i = 0; i < fddct_pkg::NUM_DIGITS; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].en       = adv;
      cell_ctl[i].load     = load;
      cell_ctl[i].edit_inc = key_edit && s1_key == fddct_pkg::KEY_K3 && cursor == 2'(i);
      cell_ctl[i].edit_dec = key_edit && s1_key == fddct_pkg::KEY_K2 && cursor == 2'(i);
      cell_ctl[i].clamp    = (i == 0);
    end

    fddct_digit_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl[i]),
      .rst_digit    (fddct_pkg::RST_DIGITS[i]),
      .preset_digit (preset_digits[i]),
      .borrow_in    (borrow[i+1]),
      .borrow_out   (borrow[i]),
      .digit        (digits[i]),
      .digit_next   (digits_next[i])
    );
  end

  // flag updates for the beat in the update stage
  always_comb begin
    running_next   = running;
    edit_mode_next = edit_mode;
    cursor_next    = cursor;
    fin_next       = 1'b0;
    leave_next     = 1'b0;
    if (tick) begin
      if (count_en && digits_next == '0) begin
        running_next = 1'b0;
        fin_next     = 1'b1;
      end
    end else if (key_run) begin
      case (s1_key)
        fddct_pkg::KEY_K1: running_next   = !running;
        fddct_pkg::KEY_K2: edit_mode_next = 1'b1;
        fddct_pkg::KEY_K3: running_next   = 1'b0;
        fddct_pkg::KEY_K4: begin
          running_next = 1'b0;
          leave_next   = 1'b1;
        end
        default: running_next = running;
      endcase
    end else begin
      case (s1_key)
        fddct_pkg::KEY_K1: begin
          if (s1_held) edit_mode_next = 1'b0;
          else cursor_next = cursor + 2'd1;
        end
        fddct_pkg::KEY_K4: edit_mode_next = 1'b0;
        default: edit_mode_next = edit_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      edit_mode <= 1'b0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        running   <= running_next;
        edit_mode <= edit_mode_next;
        cursor    <= cursor_next;
      end
      if (adv) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin   <= fin_next;
      leave <= leave_next;
    end
  end

  // state only moves when a new result is loaded, so it doubles as the result
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, leave, fin, running, cursor, edit_mode,
                     digits[3], digits[2], digits[1], digits[0]};

endmodule

// ----- rtl/core/fddct_checker.sv -----
module fddct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // offered input beat holds until taken
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable({s_tuser, s_tdata}))
    else $error("input beat changed before it was taken");

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed under stall");

  // finished only with a zero count and the timer stopped
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tdata[15:0] == 16'h0000 && !m_tdata[19])
    else $error("finished without zero count or with timer running");

  // leave only in run view with the timer stopped
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> !m_tdata[16] && !m_tdata[19] && !m_tdata[20])
    else $error("leave pulse in wrong state");

  // every digit stays decimal
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= 4'd9 && m_tdata[7:4] <= 4'd9 &&
                 m_tdata[11:8] <= 4'd9 && m_tdata[15:12] <= 4'd9)
    else $error("digit out of decimal range");

endmodule

bind four_digit_decimal_countdown_timer_core fddct_checker u_fddct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
